// ===== hw/rtl/morse_timing_decoder_assert.svh =====
// Assertion macros shared by the Morse timing decoder RTL.
// Expects clk and arst_n in the scope of each use; empty when SYNTH is defined.
`ifndef MORSE_TIMING_DECODER_ASSERT_SVH
`define MORSE_TIMING_DECODER_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define MTD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("morse_timing_decoder: assertion failed");

// next-cycle implication
`define MTD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("morse_timing_decoder: assertion failed");

`else

`define MTD_ASSERT_IMP(label, ante, cons)
`define MTD_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/mtd_pkg.sv =====
// Package for the Morse timing decoder: config struct, register indexes, code table.
// No dependencies.
`default_nettype none

package mtd_pkg;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int TABLE_LEN = 38;

	localparam logic [6:0] QMARK_CHAR = 7'h3F;

	// register index = paddr[3:2]
	typedef enum logic [1:0] {
		REG_DOT  = 2'd0,
		REG_DASH = 2'd1,
		REG_TOL  = 2'd2,
		REG_GAP  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [9:0]  dot_time;
		logic [9:0]  dash_time;
		logic [9:0]  tolerance_time;
		logic [10:0] symbol_gap;
	} cfg_t;

	// element i sits in bit i, dash is 1
	typedef struct packed {
		logic [2:0] len;
		logic [5:0] pat;
		logic [6:0] ch;
	} code_entry_t;

	localparam code_entry_t CODE_TABLE [TABLE_LEN] = '{
		'{3'd2, 6'b000010, 7'h61},  // a .-
		'{3'd4, 6'b000001, 7'h62},  // b -...
		'{3'd4, 6'b000101, 7'h63},  // c -.-.
		'{3'd3, 6'b000001, 7'h64},  // d -..
		'{3'd1, 6'b000000, 7'h65},  // e .
		'{3'd4, 6'b000100, 7'h66},  // f ..-.
		'{3'd3, 6'b000011, 7'h67},  // g --.
		'{3'd4, 6'b000000, 7'h68},  // h ....
		'{3'd2, 6'b000000, 7'h69},  // i ..
		'{3'd4, 6'b001110, 7'h6A},  // j .---
		'{3'd3, 6'b000101, 7'h6B},  // k -.-
		'{3'd4, 6'b000010, 7'h6C},  // l .-..
		'{3'd2, 6'b000011, 7'h6D},  // m --
		'{3'd2, 6'b000001, 7'h6E},  // n -.
		'{3'd3, 6'b000111, 7'h6F},  // o ---
		'{3'd4, 6'b000110, 7'h70},  // p .--.
		'{3'd4, 6'b001011, 7'h71},  // q --.-
		'{3'd3, 6'b000010, 7'h72},  // r .-.
		'{3'd3, 6'b000000, 7'h73},  // s ...
		'{3'd1, 6'b000001, 7'h74},  // t -
		'{3'd3, 6'b000100, 7'h75},  // u ..-
		'{3'd4, 6'b001000, 7'h76},  // v ...-
		'{3'd3, 6'b000110, 7'h77},  // w .--
		'{3'd4, 6'b001001, 7'h78},  // x -..-
		'{3'd4, 6'b001101, 7'h79},  // y -.--
		'{3'd4, 6'b000011, 7'h7A},  // z --..
		'{3'd5, 6'b011110, 7'h31},  // 1 .----
		'{3'd5, 6'b011100, 7'h32},  // 2 ..---
		'{3'd5, 6'b011000, 7'h33},  // 3 ...--
		'{3'd5, 6'b010000, 7'h34},  // 4 ....-
		'{3'd5, 6'b000000, 7'h35},  // 5 .....
		'{3'd5, 6'b000001, 7'h36},  // 6 -....
		'{3'd5, 6'b000011, 7'h37},  // 7 --...
		'{3'd5, 6'b000111, 7'h38},  // 8 ---..
		'{3'd5, 6'b001111, 7'h39},  // 9 ----.
		'{3'd5, 6'b011111, 7'h30},  // 0 -----
		'{3'd6, 6'b110011, 7'h20},  // space --..--
		'{3'd5, 6'b001010, 7'h0A}   // newline .-.-.
	};

endpackage

`default_nettype wire

// ===== hw/rtl/mtd_apb_regs.sv =====
// APB register bank for the Morse timing decoder (dot, dash, tolerance, gap).
// Depends on mtd_pkg.
`default_nettype none

module mtd_apb_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [mtd_pkg::ADDR_W-1:0] paddr,
	input  wire logic [mtd_pkg::DATA_W-1:0] pwdata,
	output logic      [mtd_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	output mtd_pkg::cfg_t                   cfg
);
	import mtd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dot_time       <= 10'd3;
			cfg_q.dash_time      <= 10'd9;
			cfg_q.tolerance_time <= 10'd3;
			cfg_q.symbol_gap     <= 11'd9;
		end else if (wr_en) begin
			unique case (idx)
				REG_DOT:  cfg_q.dot_time       <= pwdata[9:0];
				REG_DASH: cfg_q.dash_time      <= pwdata[9:0];
				REG_TOL:  cfg_q.tolerance_time <= pwdata[9:0];
				REG_GAP:  cfg_q.symbol_gap     <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_DOT:  prdata = DATA_W'(cfg_q.dot_time);
			REG_DASH: prdata = DATA_W'(cfg_q.dash_time);
			REG_TOL:  prdata = DATA_W'(cfg_q.tolerance_time);
			REG_GAP:  prdata = DATA_W'(cfg_q.symbol_gap);
			default:  prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mtd_code_lookup.sv =====
// Combinational Morse code table lookup: element bits and count to ASCII.
// Depends on mtd_pkg (CODE_TABLE, QMARK_CHAR).
`default_nettype none

module mtd_code_lookup #(
	parameter int MAX_ELEMENTS = 6,
	parameter int CNT_W        = 3
) (
	input  wire logic [MAX_ELEMENTS-1:0] bits,
	input  wire logic [CNT_W-1:0]        count,
	output logic      [6:0]              character,
	output logic                         unknown_code
);
	import mtd_pkg::*;

	logic [6:0] hit_ch;
	logic       hit;

	// codes are unique, so OR-ing the matching entries gives the single hit
	always_comb begin
		hit_ch = '0;
		hit    = 1'b0;
		for (int i = 0; i < TABLE_LEN; i++) begin
			if (count == CNT_W'(CODE_TABLE[i].len) &&
			    bits == MAX_ELEMENTS'(CODE_TABLE[i].pat)) begin
				hit_ch = hit_ch | CODE_TABLE[i].ch;
				hit    = 1'b1;
			end
		end
	end

	// the overflow mark never equals a table length, so it falls to '?'
	assign character    = hit ? hit_ch : QMARK_CHAR;
	assign unknown_code = !hit;

endmodule

`default_nettype wire

// ===== hw/rtl/mtd_element_tracker.sv =====
// Key edge timing, dot/dash classification and character completion.
// Depends on mtd_pkg, mtd_code_lookup and morse_timing_decoder_assert.svh.
`default_nettype none

`include "morse_timing_decoder_assert.svh"

module mtd_element_tracker #(
	parameter int MAX_ELEMENTS = 6,
	parameter int COUNT_BITS   = 12
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire mtd_pkg::cfg_t cfg,
	input  wire logic          step,
	input  wire logic          key,
	output logic               emit,
	output logic [6:0]         character,
	output logic               unknown_code
);
	import mtd_pkg::*;

	localparam int CNT_W = $clog2(MAX_ELEMENTS + 2);
	localparam int IDX_W = $clog2(MAX_ELEMENTS);
	localparam int CMP_W = (COUNT_BITS > 11) ? COUNT_BITS : 11;
	localparam logic [CNT_W-1:0] OVF_MARK = CNT_W'(MAX_ELEMENTS + 1);
	localparam logic [CNT_W-1:0] FULL     = CNT_W'(MAX_ELEMENTS);

	logic                    key_q;
	logic [COUNT_BITS-1:0]   ticks_q;
	logic [MAX_ELEMENTS-1:0] bits_q;
	logic [CNT_W-1:0]        count_q;

	logic [COUNT_BITS-1:0]   ticks_inc;
	logic [COUNT_BITS-1:0]   ticks_n;
	logic [MAX_ELEMENTS-1:0] bits_n;
	logic [CNT_W-1:0]        count_n;
	logic                    key_edge;
	logic [CMP_W-1:0]        len_ext;
	logic [CMP_W-1:0]        dot_lim;
	logic [CMP_W-1:0]        dash_lim;
	logic                    is_dot;
	logic                    is_dash;
	logic                    add_el;

	// saturating tick counter; on an edge the incremented value is the length
	assign ticks_inc = (ticks_q == '1) ? ticks_q : ticks_q + 1'b1;
	assign key_edge  = key != key_q;
	assign ticks_n   = key_edge ? '0 : ticks_inc;

	// press length windows
	assign len_ext  = CMP_W'(ticks_inc);
	assign dot_lim  = CMP_W'({1'b0, cfg.dot_time} + {1'b0, cfg.tolerance_time});
	assign dash_lim = CMP_W'({1'b0, cfg.dash_time} + {1'b0, cfg.tolerance_time});
	assign is_dot   = len_ext < dot_lim;
	assign is_dash  = !is_dot && (len_ext < dash_lim);
	assign add_el   = key_edge && key_q && (is_dot || is_dash);

	// append the element, or mark overflow when the buffer is full
	always_comb begin
		bits_n  = bits_q;
		count_n = count_q;
		if (add_el) begin
			if (count_q < FULL) begin
				bits_n[count_q[IDX_W-1:0]] = is_dash;
				count_n = count_q + 1'b1;
			end else begin
				count_n = OVF_MARK;
			end
		end
	end

	// character ends after a long enough key-up gap
	assign emit = (count_n != '0) && !key &&
	              (CMP_W'(ticks_n) > CMP_W'(cfg.symbol_gap));

	mtd_code_lookup #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.CNT_W        (CNT_W)
	) u_lookup (
		.bits         (bits_n),
		.count        (count_n),
		.character    (character),
		.unknown_code (unknown_code)
	);

	// state update, one step per accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= 1'b0;
			ticks_q <= '0;
			bits_q  <= '0;
			count_q <= '0;
		end else if (step) begin
			key_q   <= key;
			ticks_q <= ticks_n;
			bits_q  <= emit ? '0 : bits_n;
			count_q <= emit ? '0 : count_n;
		end
	end

	`MTD_ASSERT_IMP(a_count_range, 1'b1, count_q <= OVF_MARK)
	`MTD_ASSERT_NXT(a_clear_after_emit, step && emit, count_q == '0 && bits_q == '0)
	`MTD_ASSERT_IMP(a_unknown_is_qmark, emit && unknown_code, character == QMARK_CHAR)

endmodule

`default_nettype wire

// ===== hw/rtl/morse_timing_decoder.sv =====
// Morse timing decoder top level: input register, element tracker, result register.
// Depends on mtd_pkg, mtd_apb_regs, mtd_element_tracker.
//
// Usage:
//   s_* stream: one request per key sample tick, s_tdata[0] = key level (1 = pressed).
//   m_* stream: one decoded character per completed Morse symbol.
//   APB port: dot_time @0x0, dash_time @0x4, tolerance_time @0x8, symbol_gap @0xC.
//   Write registers only while no samples are in flight.
// Flow: a sample is taken into the input register, then processed into the
//   result register when the result slot is free or draining; a character appears
//   on m_tvalid once the sample that completes it has been processed.
// Throughput: one sample per cycle while the result is not held; the only loop
//   is the update of the key state, tick counter and element buffer.
// Reset: key up, counter and element buffer cleared, registers at 3/9/3/9,
//   both stream registers empty.
// Stall: a held result keeps m_tdata; the input register still fills, and
//   s_tready drops only when both the input register and the result are held.
`default_nettype none

module morse_timing_decoder #(
	parameter int MAX_ELEMENTS = 6,
	parameter int COUNT_BITS   = 12
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// slave stream
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [7:0]                 s_tdata,   // [0] key_down, [7:1] zero
	// master stream
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic      [7:0]                 m_tdata,   // [6:0] character, [7] unknown_code
	// configuration
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [mtd_pkg::ADDR_W-1:0] paddr,
	input  wire logic [mtd_pkg::DATA_W-1:0] pwdata,
	output logic      [mtd_pkg::DATA_W-1:0] prdata,
	output logic                            pready
);
	import mtd_pkg::*;

	cfg_t       cfg;
	logic       valid_s1;
	logic       key_s1;
	logic       adv;
	logic       emit;
	logic [6:0] res_char;
	logic       res_unknown;
	logic       out_valid_q;
	logic [7:0] out_data_q;

	mtd_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// the held sample moves on when the result slot is free or draining
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			key_s1 <= s_tdata[0];
		end
	end

	mtd_element_tracker #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.COUNT_BITS   (COUNT_BITS)
	) u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.step         (adv),
		.key          (key_s1),
		.emit         (emit),
		.character    (res_char),
		.unknown_code (res_unknown)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			out_data_q <= {res_unknown, res_char};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

// ===== verif/tb_morse_timing_decoder.sv =====
// Self-checking testbench for morse_timing_decoder: key samples in, decoded characters out.
// Predicts most characters with a timing model of its own; uses mtd_pkg for types and indexes.
`default_nettype none

module tb_morse_timing_decoder;
	import mtd_pkg::*;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 12;
	localparam int CNT_BITS      = 12;
	localparam int MAX_ELEMS     = 6;
	localparam int N_CODES       = 38;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT   = 100000;
	localparam logic [2:0] OVERFLOW_NUM = 3'd7;
	localparam logic [CNT_BITS-1:0] COUNT_SAT = '1;

	typedef struct packed {
		logic [6:0] ch;
		logic       unk;
	} char_result_t;

	// directed run: a key level held for some ticks, optional typed result on the last tick
	typedef struct {
		bit          lvl;
		int          ticks;
		bit          typed;
		byte unsigned ch;
		bit          unk;
	} key_run_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] s_tdata;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	// decoder state tracked by the testbench
	cfg_t dec_cfg;
	logic key_held;
	logic [CNT_BITS-1:0] edge_count;
	logic [MAX_ELEMS-1:0] elem_pat;
	logic [2:0] elem_num;

	char_result_t expected_chars[$];
	bit key_plan[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int n_fail = 0;
	int n_keys = 0;
	int n_chars = 0;
	int n_unknown = 0;
	int n_settings = 0;

	string morse_code [N_CODES] = '{
		".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
		"-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
		"..-", "...-", ".--", "-..-", "-.--", "--..", ".----", "..---", "...--",
		"....-", ".....", "-....", "--...", "---..", "----.", "-----", "--..--",
		".-.-."
	};
	byte unsigned morse_chr [N_CODES] = '{
		"a", "b", "c", "d", "e", "f", "g", "h", "i", "j",
		"k", "l", "m", "n", "o", "p", "q", "r", "s", "t",
		"u", "v", "w", "x", "y", "z", "1", "2", "3",
		"4", "5", "6", "7", "8", "9", "0", " ",
		"\n"
	};

	// directed sequence, timed for dot 1, dash 2, tolerance 1, symbol gap 1
	localparam int N_DIR = 43;
	key_run_t dir_runs [N_DIR] = '{
		'{1'b0, 2, 1'b0, 8'h00, 1'b0},  // key up, no edge
		'{1'b1, 1, 1'b0, 8'h00, 1'b0},  // first edge is key down
		'{1'b0, 3, 1'b1, "e",   1'b0},  // shortest dot
		'{1'b1, 2, 1'b0, 8'h00, 1'b0},
		'{1'b0, 3, 1'b1, "t",   1'b0},  // longest dash
		'{1'b1, 3, 1'b0, 8'h00, 1'b0},  // press too long: nothing stored
		'{1'b0, 3, 1'b0, 8'h00, 1'b0},
		'{1'b1, 1, 1'b0, 8'h00, 1'b0},
		'{1'b0, 2, 1'b0, 8'h00, 1'b0},  // longest gap inside a character
		'{1'b1, 2, 1'b0, 8'h00, 1'b0},
		'{1'b0, 3, 1'b1, "a",   1'b0},
		'{1'b1, 2, 1'b0, 8'h00, 1'b0},  // six elements: space
		'{1'b0, 1, 1'b0, 8'h00, 1'b0},
		'{1'b1, 2, 1'b0, 8'h00, 1'b0},
		'{1'b0, 1, 1'b0, 8'h00, 1'b0},
		'{1'b1, 1, 1'b0, 8'h00, 1'b0},
		'{1'b0, 1, 1'b0, 8'h00, 1'b0},
		'{1'b1, 1, 1'b0, 8'h00, 1'b0},
		'{1'b0, 1, 1'b0, 8'h00, 1'b0},
		'{1'b1, 2, 1'b0, 8'h00, 1'b0},
		'{1'b0, 1, 1'b0, 8'h00, 1'b0},
		'{1'b1, 2, 1'b0, 8'h00, 1'b0},
		'{1'b0, 3, 1'b1, " ",   1'b0},
		'{1'b1, 1, 1'b0, 8'h00, 1'b0},  // unknown code ..--
		'{1'b0, 1, 1'b0, 8'h00, 1'b0},
		'{1'b1, 1, 1'b0, 8'h00, 1'b0},
		'{1'b0, 1, 1'b0, 8'h00, 1'b0},
		'{1'b1, 2, 1'b0, 8'h00, 1'b0},
		'{1'b0, 1, 1'b0, 8'h00, 1'b0},
		'{1'b1, 2, 1'b0, 8'h00, 1'b0},
		'{1'b0, 3, 1'b1, "?",   1'b1},
		'{1'b1, 1, 1'b0, 8'h00, 1'b0},  // seven dots, the last one sent after this table: overflow
		'{1'b0, 1, 1'b0, 8'h00, 1'b0},
		'{1'b1, 1, 1'b0, 8'h00, 1'b0},
		'{1'b0, 1, 1'b0, 8'h00, 1'b0},
		'{1'b1, 1, 1'b0, 8'h00, 1'b0},
		'{1'b0, 1, 1'b0, 8'h00, 1'b0},
		'{1'b1, 1, 1'b0, 8'h00, 1'b0},
		'{1'b0, 1, 1'b0, 8'h00, 1'b0},
		'{1'b1, 1, 1'b0, 8'h00, 1'b0},
		'{1'b0, 1, 1'b0, 8'h00, 1'b0},
		'{1'b1, 1, 1'b0, 8'h00, 1'b0},
		'{1'b0, 1, 1'b0, 8'h00, 1'b0}
	};

	morse_timing_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [0] key_down, [7:1] zero
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [6:0] character, [7] unknown_code
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #(CLK_HALF) clk = ~clk;

	// receiver back-pressure
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// character checker
	always @(posedge clk) begin
		char_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			n_chars++;
			if (m_tdata[7])
				n_unknown++;
			if (expected_chars.size() == 0) begin
				$error("unexpected character %h (unknown_code %0d)", m_tdata[6:0], m_tdata[7]);
				n_fail++;
			end else begin
				want = expected_chars.pop_front();
				if (m_tdata[6:0] !== want.ch) begin
					$error("character: expected %h, got %h", want.ch, m_tdata[6:0]);
					n_fail++;
				end
				if (m_tdata[7] !== want.unk) begin
					$error("unknown_code: expected %0d, got %0d", want.unk, m_tdata[7]);
					n_fail++;
				end
			end
		end
	end

	initial begin
		#(CLK_HALF * 2 * 2000000);
		$display("TEST FAILED");
		$finish;
	end

	function automatic void add_element(input bit is_dash);
		if (elem_num < MAX_ELEMS) begin
			elem_pat[elem_num] = is_dash;
			elem_num++;
		end else begin
			elem_num = OVERFLOW_NUM;
		end
	endfunction

	// one key tick through the timing decoder; returns 1 when a character completes
	function automatic bit step_decoder(input bit lvl, output logic [6:0] ch, output logic unk);
		string code;
		ch = QMARK_CHAR;
		unk = 1'b1;
		if (edge_count != COUNT_SAT)
			edge_count++;
		if (lvl != key_held) begin
			if (key_held) begin
				if (int'(edge_count) < int'(dec_cfg.dot_time) + int'(dec_cfg.tolerance_time))
					add_element(1'b0);
				else if (int'(edge_count) < int'(dec_cfg.dash_time) + int'(dec_cfg.tolerance_time))
					add_element(1'b1);
			end
			key_held = lvl;
			edge_count = '0;
		end
		if (elem_num == 0 || key_held || int'(edge_count) <= int'(dec_cfg.symbol_gap))
			return 1'b0;
		if (elem_num != OVERFLOW_NUM) begin
			code = "";
			for (int i = 0; i < elem_num; i++)
				code = {code, elem_pat[i] ? "-" : "."};
			for (int i = 0; i < N_CODES; i++) begin
				if (morse_code[i] == code) begin
					ch = morse_chr[i][6:0];
					unk = 1'b0;
					break;
				end
			end
		end
		elem_pat = '0;
		elem_num = '0;
		return 1'b1;
	endfunction

	// one key sample request; called and returning at a falling edge
	task automatic send_key(input bit lvl, input bit typed, input byte unsigned t_ch,
			input bit t_unk);
		logic [6:0] p_ch;
		logic p_unk;
		bit done;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, lvl};
		do @(posedge clk); while (!s_tready);
		n_keys++;
		done = step_decoder(lvl, p_ch, p_unk);
		if (typed)
			expected_chars.push_back('{t_ch[6:0], t_unk});
		else if (done)
			expected_chars.push_back('{p_ch, p_unk});
		@(negedge clk);
	endtask

	// wait out outstanding characters and the pipeline, then return at a falling edge
	task automatic settle();
		int waited;
		waited = 0;
		while (expected_chars.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_chars.size() != 0) begin
			$error("%0d expected characters never arrived", expected_chars.size());
			n_fail += expected_chars.size();
			expected_chars.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_DOT:  dec_cfg.dot_time = val[9:0];
			REG_DASH: dec_cfg.dash_time = val[9:0];
			REG_TOL:  dec_cfg.tolerance_time = val[9:0];
			REG_GAP:  dec_cfg.symbol_gap = val[10:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apb_check(input reg_idx_t idx, input logic [DATA_W-1:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			$error("%s: expected %h, got %h", idx.name(), want, prdata);
			n_fail++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// new timing setting; upper write bits are random and must be dropped
	task automatic configure(input int dot, input int dash, input int tol, input int gap);
		logic [DATA_W-1:0] v;
		settle();
		n_settings++;
		v = $urandom();
		v[9:0] = dot[9:0];
		apb_write(REG_DOT, v);
		v = $urandom();
		v[9:0] = dash[9:0];
		apb_write(REG_DASH, v);
		v = $urandom();
		v[9:0] = tol[9:0];
		apb_write(REG_TOL, v);
		v = $urandom();
		v[10:0] = gap[10:0];
		apb_write(REG_GAP, v);
		apb_check(REG_DOT, {22'd0, dec_cfg.dot_time});
		apb_check(REG_DASH, {22'd0, dec_cfg.dash_time});
		apb_check(REG_TOL, {22'd0, dec_cfg.tolerance_time});
		apb_check(REG_GAP, {21'd0, dec_cfg.symbol_gap});
	endtask

	task automatic add_run(input bit lvl, input int n);
		repeat (n) key_plan.push_back(lvl);
	endtask

	// endpoints come up often so window edges get hit
	function automatic int pick_len(input int lo, input int hi);
		if (hi < lo)
			hi = lo;
		case ($urandom_range(0, 3))
			0: return lo;
			1: return hi;
			default: return $urandom_range(lo, hi);
		endcase
	endfunction

	// one character's worth of key ticks: mostly well timed codes, some noise
	task automatic queue_char();
		int dot_lim;
		int dash_lim;
		int gap;
		int kind;
		int lo;
		int hi;
		string code;
		dot_lim = int'(dec_cfg.dot_time) + int'(dec_cfg.tolerance_time);
		dash_lim = int'(dec_cfg.dash_time) + int'(dec_cfg.tolerance_time);
		gap = int'(dec_cfg.symbol_gap);
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			repeat ($urandom_range(3, 10))
				add_run(1'($urandom_range(0, 1)), $urandom_range(1, 6));
		end else begin
			if (kind < 80) begin
				code = morse_code[$urandom_range(0, N_CODES - 1)];
			end else begin
				code = "";
				repeat ($urandom_range(1, 8))
					code = {code, $urandom_range(0, 1) ? "-" : "."};
			end
			for (int i = 0; i < code.len(); i++) begin
				// stray over-long press
				if ($urandom_range(0, 99) < 8) begin
					lo = (dash_lim > dot_lim) ? dash_lim : dot_lim;
					lo = (lo > 1) ? lo : 1;
					add_run(1'b1, pick_len(lo, lo + 3));
					add_run(1'b0, pick_len(1, gap + 1));
				end
				if (code[i] == "-") begin
					lo = (dot_lim > 1) ? dot_lim : 1;
					hi = dash_lim - 1;
				end else begin
					lo = 1;
					hi = dot_lim - 1;
				end
				if (hi < lo) begin
					lo = 1;
					hi = 4;
				end
				add_run(1'b1, pick_len(lo, hi));
				if (i != code.len() - 1)
					add_run(1'b0, ($urandom_range(0, 99) < 4) ? gap + 2 : pick_len(1, gap + 1));
			end
		end
		add_run(1'b0, pick_len(gap + 2, gap + 4));
	endtask

	task automatic play_plan();
		while (key_plan.size() != 0)
			send_key(key_plan.pop_front(), 1'b0, 8'h00, 1'b0);
	endtask

	task automatic play_chars(input int n, input bit pause_mid);
		for (int i = 0; i < n; i++) begin
			if (pause_mid && i == n / 2) begin
				// hold off until every outstanding character is back
				s_tvalid <= 1'b0;
				while (expected_chars.size() != 0) @(posedge clk);
				@(negedge clk);
			end
			queue_char();
			play_plan();
		end
		s_tvalid <= 1'b0;
	endtask

	initial begin
		s_tvalid <= 1'b0;
		s_tdata <= 8'd0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		dec_cfg = '{dot_time: 10'd3, dash_time: 10'd9, tolerance_time: 10'd3,
			symbol_gap: 11'd9};
		key_held = 1'b0;
		edge_count = '0;
		elem_pat = '0;
		elem_num = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// registers come out of reset at their defaults
		apb_check(REG_DOT, 32'd3);
		apb_check(REG_DASH, 32'd9);
		apb_check(REG_TOL, 32'd3);
		apb_check(REG_GAP, 32'd9);

		// directed sequence
		configure(1, 2, 1, 1);
		foreach (dir_runs[r]) begin
			for (int k = 0; k < dir_runs[r].ticks; k++)
				send_key(dir_runs[r].lvl, dir_runs[r].typed && k == dir_runs[r].ticks - 1,
					dir_runs[r].ch, dir_runs[r].unk);
		end
		// seventh dot; the overflow ends after a full gap
		send_key(1'b1, 1'b0, 8'h00, 1'b0);
		send_key(1'b0, 1'b0, 8'h00, 1'b0);
		send_key(1'b0, 1'b0, 8'h00, 1'b0);
		send_key(1'b0, 1'b1, "?", 1'b1);
		s_tvalid <= 1'b0;

		// random characters under a range of timings and flow patterns
		configure(3, 9, 3, 9);
		play_chars(2, 1'b0);
		configure(1, 3, 1, 2);
		send_idle_pct = 56;
		play_chars(4, 1'b1);
		configure(2, 4, 0, 3);
		send_idle_pct = 0;
		recv_stall_pct = 56;
		play_chars(4, 1'b0);
		configure(1, 2, 1, 1);
		send_idle_pct = 37;
		recv_stall_pct = 37;
		play_chars(6, 1'b0);
		configure(0, 0, 3, 1);
		play_chars(3, 1'b0);
		configure(1, 1, 0, 1);
		send_idle_pct = 56;
		recv_stall_pct = 0;
		play_chars(2, 1'b0);
		configure(2, 5, 1, 4);
		send_idle_pct = 0;
		recv_stall_pct = 56;
		play_chars(3, 1'b1);

		// widest register values read back; then dot, dash and gap at their window limits
		configure(1023, 1023, 1023, 2047);
		configure(10, 20, 5, 25);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		add_run(1'b1, 14);
		add_run(1'b0, 26);
		add_run(1'b1, 24);
		add_run(1'b0, 27);
		add_run(1'b1, 25);
		add_run(1'b0, 4);
		play_plan();
		s_tvalid <= 1'b0;

		configure(1, 3, 2, 2);
		send_idle_pct = 37;
		recv_stall_pct = 37;
		play_chars(4, 1'b0);

		settle();
		$display("Sent %0d key samples under %0d timing settings; %0d characters checked, %0d unknown.",
			n_keys, n_settings, n_chars, n_unknown);
		if (n_fail == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/mtd_pkg.sv
hw/rtl/mtd_apb_regs.sv
hw/rtl/mtd_code_lookup.sv
hw/rtl/mtd_element_tracker.sv
hw/rtl/morse_timing_decoder.sv
verif/tb_morse_timing_decoder.sv
